@@ sv/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] CLEAR_LIMIT_RESET = 8'd9;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_ST_A   = 5'd1,
		PH_ST_B   = 5'd2,
		PH_CLR_LO = 5'd3,
		PH_ST_C   = 5'd4,
		PH_ST_D   = 5'd5,
		PH_BIT_LO = 5'd6,
		PH_BIT_HI = 5'd7,
		PH_ACK_LO = 5'd8,
		PH_ACK_HI = 5'd9,
		PH_SP_A   = 5'd10,
		PH_SP_B   = 5'd11,
		PH_SP_C   = 5'd12
	} phase_t;

	typedef struct packed {
		logic       tick;
		logic [1:0] req_type;
		logic [7:0] tx_byte;
		logic       first_byte;
		logic       last_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_done;
		logic [7:0] rx_byte;
		logic       ack_level;
		logic       bus_clear_fail;
	} result_t;

endpackage

@@ sv/i2cmbe_core.sv @@
module i2cmbe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  i2cmbe_pkg::item_t   item,
	input  logic [7:0]          clear_pulse_limit,
	output i2cmbe_pkg::result_t res
);
	import i2cmbe_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] pulse_cnt_q, pulse_cnt_d;
	logic       is_read_q, is_read_d;
	logic       is_last_q, is_last_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       ack_q, ack_d;
	logic [7:0] rx_q, rx_d;
	logic       fail_q, fail_d;
	logic       done;

	logic       req_ok;
	logic       req_rd;
	logic       clear_go;
	logic [3:0] cnt_inc;
	logic       more_bits;
	logic [7:0] shifted;

	assign req_ok    = (item.req_type == REQ_WRITE) || (item.req_type == REQ_READ);
	assign req_rd    = (item.req_type == REQ_READ);
	assign clear_go  = !item.sda_in && (pulse_cnt_q < clear_pulse_limit);
	assign cnt_inc   = bit_cnt_q + 4'd1;
	assign more_bits = (cnt_inc < BITS_PER_BYTE);
	assign shifted   = {shift_q[6:0], is_read_q & item.sda_in};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (phase_q == PH_IDLE) begin
			if (req_ok) begin
				phase_d = item.first_byte ? PH_ST_A : PH_BIT_LO;
			end
		end else if (item.tick) begin
			case (phase_q)
				PH_ST_A:   phase_d = PH_ST_B;
				PH_ST_B:   phase_d = clear_go ? PH_CLR_LO : PH_ST_C;
				PH_CLR_LO: phase_d = PH_ST_B;
				PH_ST_C:   phase_d = PH_ST_D;
				PH_ST_D:   phase_d = PH_BIT_LO;
				PH_BIT_LO: phase_d = PH_BIT_HI;
				PH_BIT_HI: phase_d = more_bits ? PH_BIT_LO : PH_ACK_LO;
				PH_ACK_LO: phase_d = PH_ACK_HI;
				PH_ACK_HI: phase_d = is_last_q ? PH_SP_A : PH_IDLE;
				PH_SP_A:   phase_d = PH_SP_B;
				PH_SP_B:   phase_d = PH_SP_C;
				PH_SP_C:   phase_d = PH_IDLE;
				default:   phase_d = PH_IDLE;
			endcase
		end
	end

	// line levels and datapath
	always_comb begin
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		pulse_cnt_d = pulse_cnt_q;
		is_read_d   = is_read_q;
		is_last_d   = is_last_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		ack_d       = ack_q;
		rx_d        = rx_q;
		fail_d      = fail_q;
		done        = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (req_ok) begin
				is_read_d = req_rd;
				is_last_d = item.last_byte;
				shift_d   = req_rd ? 8'd0 : item.tx_byte;
				if (item.first_byte) begin
					fail_d      = 1'b0;
					pulse_cnt_d = 8'd0;
					sda_d       = 1'b1;
				end else begin
					bit_cnt_d = 4'd0;
					sda_d     = req_rd ? 1'b1 : item.tx_byte[7];
				end
			end
		end else if (item.tick) begin
			case (phase_q)
				PH_ST_A: begin
					scl_d = 1'b1;
				end
				PH_ST_B: begin
					if (clear_go) begin
						scl_d       = 1'b0;
						pulse_cnt_d = pulse_cnt_q + 8'd1;
					end else begin
						if (!item.sda_in) begin
							fail_d = 1'b1;
						end
						sda_d = 1'b0;
					end
				end
				PH_CLR_LO: begin
					scl_d = 1'b1;
				end
				PH_ST_C: begin
					scl_d = 1'b0;
				end
				PH_ST_D: begin
					bit_cnt_d = 4'd0;
					sda_d     = is_read_q ? 1'b1 : shift_q[7];
				end
				PH_BIT_LO: begin
					scl_d = 1'b1;
				end
				PH_BIT_HI: begin
					shift_d   = shifted;
					scl_d     = 1'b0;
					bit_cnt_d = cnt_inc;
					if (more_bits) begin
						sda_d = is_read_q ? 1'b1 : shifted[7];
					end else if (is_read_q) begin
						rx_d  = shifted;
						sda_d = is_last_q;  // NACK on the last read
					end else begin
						sda_d = 1'b1;       // release for the slave's ack
					end
				end
				PH_ACK_LO: begin
					scl_d = 1'b1;
				end
				PH_ACK_HI: begin
					if (!is_read_q) begin
						ack_d = item.sda_in;
					end
					scl_d = 1'b0;
					sda_d = is_last_q ? 1'b0 : is_read_q;
					done  = !is_last_q;
				end
				PH_SP_A: begin
					scl_d = 1'b1;
				end
				PH_SP_B: begin
					sda_d = 1'b1;
				end
				PH_SP_C: begin
					done = 1'b1;
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 8'd0;
			pulse_cnt_q <= 8'd0;
			is_read_q   <= 1'b0;
			is_last_q   <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b1;
			rx_q        <= 8'd0;
			fail_q      <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			pulse_cnt_q <= pulse_cnt_d;
			is_read_q   <= is_read_d;
			is_last_q   <= is_last_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			ack_q       <= ack_d;
			rx_q        <= rx_d;
			fail_q      <= fail_d;
		end
	end

	assign res.scl_out        = scl_d;
	assign res.sda_out        = sda_d;
	assign res.busy_res       = (phase_d != PH_IDLE);
	assign res.byte_done      = done;
	assign res.rx_byte        = rx_d;
	assign res.ack_level      = ack_d;
	assign res.bus_clear_fail = fail_d;

`ifndef SYNTHESIS
	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= BITS_PER_BYTE)
		else $error("bit count past one byte");

	a_clr_pulse_counted: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLR_LO |-> pulse_cnt_q != 8'd0)
		else $error("clear pulse not counted");

	a_scl_low_in_low_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLR_LO || phase_q == PH_ACK_LO || phase_q == PH_ST_D) |-> !scl_q)
		else $error("scl high in a low phase");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("byte done without returning idle");
`endif

endmodule

@@ sv/i2c_master_byte_engine_top.sv @@
// A result appears on out_valid once its item is taken into the input register and the
// core's result is then captured in the result register; out_stall can hold it in between.
// Throughput: one item per cycle; the only stall comes from out_stall.
// Each item steps the byte sequencer once; apart from a request taken in idle, line changes wait for tick.
// Reset (arst_n low, asynchronous): sequencer idle, both lines released,
// ack_level 1, rx_byte 0, clear_pulse_limit 9, no item held; the result register is not reset.
module i2c_master_byte_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	input  logic [1:0] req_type,
	input  logic [7:0] tx_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_out,
	output logic       sda_out,
	output logic       busy_res,
	output logic       byte_done,
	output logic [7:0] rx_byte,
	output logic       ack_level,
	output logic       bus_clear_fail
);
	import i2cmbe_pkg::*;

	logic [7:0] clear_limit_q;
	item_t      item_s1;
	logic       vld_s1;
	logic       adv;
	logic       take;
	result_t    res_c;
	result_t    res_s2;
	logic       vld_s2;

	assign adv      = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_limit_q <= CLEAR_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			clear_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{tick: tick, req_type: req_type, tx_byte: tx_byte,
				first_byte: first_byte, last_byte: last_byte, sda_in: sda_in};
		end
	end

	i2cmbe_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (adv),
		.item              (item_s1),
		.clear_pulse_limit (clear_limit_q),
		.res               (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid      = vld_s2;
	assign scl_out        = res_s2.scl_out;
	assign sda_out        = res_s2.sda_out;
	assign busy_res       = res_s2.busy_res;
	assign byte_done      = res_s2.byte_done;
	assign rx_byte        = res_s2.rx_byte;
	assign ack_level      = res_s2.ack_level;
	assign bus_clear_fail = res_s2.bus_clear_fail;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import i2cmbe_pkg::*;

	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int MAX_PRINTED = 30;

	typedef enum logic [1:0] {SDA_HIGH, SDA_LOW, SDA_RAND} sda_drive_t;

	typedef struct {
		logic [1:0] req;
		logic [7:0] tx;
		logic       first;
		logic       last;
		sda_drive_t sda;
		bit         typed;
		result_t    want;
	} plan_row_t;

	localparam result_t IDLE_LINES = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		byte_done: 1'b0, rx_byte: 8'h00, ack_level: 1'b1, bus_clear_fail: 1'b0};

	// each row is one byte request; its item is then repeated, with tick set at random, until idle
	plan_row_t byte_plan [10] = '{
		'{REQ_NONE,  8'h00, 1'b0, 1'b0, SDA_HIGH, 1'b1, IDLE_LINES},
		'{REQ_SPARE, 8'hFF, 1'b1, 1'b1, SDA_HIGH, 1'b1, IDLE_LINES},
		'{REQ_WRITE, 8'h00, 1'b1, 1'b0, SDA_HIGH, 1'b0, '0},
		'{REQ_WRITE, 8'hFF, 1'b0, 1'b0, SDA_LOW,  1'b0, '0},
		'{REQ_READ,  8'h00, 1'b0, 1'b0, SDA_RAND, 1'b0, '0},
		'{REQ_READ,  8'hFF, 1'b0, 1'b1, SDA_HIGH, 1'b0, '0},
		'{REQ_WRITE, 8'hA5, 1'b1, 1'b1, SDA_LOW,  1'b0, '0},
		'{REQ_WRITE, 8'h5A, 1'b1, 1'b0, SDA_RAND, 1'b0, '0},
		'{REQ_READ,  8'h00, 1'b0, 1'b1, SDA_LOW,  1'b0, '0},
		'{REQ_WRITE, 8'h80, 1'b1, 1'b1, SDA_HIGH, 1'b0, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic       tick;
	logic [1:0] req_type;
	logic [7:0] tx_byte;
	logic       first_byte;
	logic       last_byte;
	logic       sda_in;
	logic       out_valid;
	logic       out_stall;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       byte_done;
	logic [7:0] rx_byte;
	logic       ack_level;
	logic       bus_clear_fail;

	// predicted sequencer state
	phase_t     seq_ph;
	logic [3:0] seq_bits;
	logic [7:0] seq_shift;
	logic [7:0] seq_pulses;
	logic       seq_rd;
	logic       seq_last;
	logic       seq_scl;
	logic       seq_sda;
	logic       seq_ack;
	logic [7:0] seq_rx;
	logic       seq_fail;
	logic [7:0] pulse_limit;

	result_t    expected_lines [$];

	int  n_mismatch;
	int  n_items;
	int  n_active;
	int  n_checked;
	int  n_writes_done;
	int  n_reads_done;
	int  n_clear_fails;
	bit  calm;
	bit  want_hold;
	bit  txn_open;
	bit  sda_stuck;
	bit  big_stuck_due;
	int  stuck_pct;

	i2c_master_byte_engine_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tick          (tick),
		.req_type      (req_type),
		.tx_byte       (tx_byte),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.sda_in        (sda_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.scl_out       (scl_out),
		.sda_out       (sda_out),
		.busy_res      (busy_res),
		.byte_done     (byte_done),
		.rx_byte       (rx_byte),
		.ack_level     (ack_level),
		.bus_clear_fail(bus_clear_fail)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		if (n_mismatch < MAX_PRINTED) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		n_mismatch++;
	endtask

	function automatic void load_first_bit();
		seq_bits = 4'd0;
		seq_sda = seq_rd ? 1'b1 : seq_shift[7];
		seq_ph = PH_BIT_LO;
	endfunction

	// one item through the sequencer; returns the line state it leaves behind
	function automatic result_t sequencer_step(input item_t it);
		result_t r;
		logic done;
		done = 1'b0;
		if (seq_ph == PH_IDLE) begin
			if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
				seq_rd = (it.req_type == REQ_READ);
				seq_last = it.last_byte;
				seq_shift = seq_rd ? 8'h00 : it.tx_byte;
				if (it.first_byte) begin
					seq_fail = 1'b0;
					seq_pulses = 8'd0;
					seq_sda = 1'b1;
					seq_ph = PH_ST_A;
				end else begin
					load_first_bit();
				end
			end
		end else if (it.tick) begin
			case (seq_ph)
				PH_ST_A: begin
					seq_scl = 1'b1;
					seq_ph = PH_ST_B;
				end
				PH_ST_B: begin
					if (!it.sda_in && seq_pulses < pulse_limit) begin
						seq_scl = 1'b0;
						seq_pulses = seq_pulses + 8'd1;
						seq_ph = PH_CLR_LO;
					end else begin
						if (!it.sda_in) begin
							seq_fail = 1'b1;
							n_clear_fails++;
						end
						seq_sda = 1'b0;
						seq_ph = PH_ST_C;
					end
				end
				PH_CLR_LO: begin
					seq_scl = 1'b1;
					seq_ph = PH_ST_B;
				end
				PH_ST_C: begin
					seq_scl = 1'b0;
					seq_ph = PH_ST_D;
				end
				PH_ST_D: load_first_bit();
				PH_BIT_LO: begin
					seq_scl = 1'b1;
					seq_ph = PH_BIT_HI;
				end
				PH_BIT_HI: begin
					seq_shift = {seq_shift[6:0], seq_rd ? it.sda_in : 1'b0};
					seq_scl = 1'b0;
					seq_bits = seq_bits + 4'd1;
					if (seq_bits < BITS_PER_BYTE) begin
						seq_sda = seq_rd ? 1'b1 : seq_shift[7];
						seq_ph = PH_BIT_LO;
					end else begin
						if (seq_rd) begin
							seq_rx = seq_shift;
							seq_sda = seq_last;
						end else begin
							seq_sda = 1'b1;
						end
						seq_ph = PH_ACK_LO;
					end
				end
				PH_ACK_LO: begin
					seq_scl = 1'b1;
					seq_ph = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					if (!seq_rd) begin
						seq_ack = it.sda_in;
					end
					seq_scl = 1'b0;
					seq_sda = seq_rd;
					if (seq_last) begin
						seq_sda = 1'b0;
						seq_ph = PH_SP_A;
					end else begin
						seq_ph = PH_IDLE;
						done = 1'b1;
					end
				end
				PH_SP_A: begin
					seq_scl = 1'b1;
					seq_ph = PH_SP_B;
				end
				PH_SP_B: begin
					seq_sda = 1'b1;
					seq_ph = PH_SP_C;
				end
				PH_SP_C: begin
					seq_ph = PH_IDLE;
					done = 1'b1;
				end
				default: seq_ph = PH_IDLE;
			endcase
		end
		if (done) begin
			if (seq_rd) n_reads_done++;
			else n_writes_done++;
		end
		r.scl_out = seq_scl;
		r.sda_out = seq_sda;
		r.busy_res = (seq_ph != PH_IDLE);
		r.byte_done = done;
		r.rx_byte = seq_rx;
		r.ack_level = seq_ack;
		r.bus_clear_fail = seq_fail;
		return r;
	endfunction

	task automatic offer(input item_t it, input bit typed, input result_t want);
		result_t r;
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick <= it.tick;
		req_type <= it.req_type;
		tx_byte <= it.tx_byte;
		first_byte <= it.first_byte;
		last_byte <= it.last_byte;
		sda_in <= it.sda_in;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.tick || seq_ph == PH_IDLE) n_active++;
		r = sequencer_step(it);
		expected_lines.push_back(typed ? want : r);
		n_items++;
	endtask

	function automatic logic pick_sda(input sda_drive_t mode);
		case (mode)
			SDA_HIGH: return 1'b1;
			SDA_LOW:  return 1'b0;
			default:  return logic'($urandom_range(0, 1));
		endcase
	endfunction

	// mostly well-formed transfers: start on the first byte, stop on the last
	function automatic item_t next_random_item();
		item_t it;
		int r;
		it.tick = ($urandom_range(0, 99) < 70);
		it.tx_byte = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 15) == 0) it.tx_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		it.first_byte = logic'($urandom_range(0, 1));
		it.last_byte = logic'($urandom_range(0, 1));
		it.req_type = 2'($urandom_range(0, 3));
		if (seq_ph == PH_IDLE) begin
			r = $urandom_range(0, 99);
			if (r < 8) it.req_type = $urandom_range(0, 1) ? REQ_SPARE : REQ_NONE;
			else it.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
			if (r >= 18) begin
				it.first_byte = !txn_open || ($urandom_range(0, 9) == 0);
				it.last_byte = ($urandom_range(0, 2) == 0);
			end
			if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
				txn_open = !it.last_byte;
				sda_stuck = 1'b0;
				if (it.first_byte) begin
					if (big_stuck_due) begin
						sda_stuck = 1'b1;
						big_stuck_due = 1'b0;
					end else begin
						sda_stuck = ($urandom_range(0, 99) < stuck_pct);
					end
				end
			end
		end else if (!(seq_ph inside {PH_ST_A, PH_ST_B, PH_CLR_LO})) begin
			sda_stuck = 1'b0;
		end
		it.sda_in = sda_stuck ? 1'b0 : ($urandom_range(0, 99) >= 30);
		return it;
	endfunction

	task automatic run_to_idle();
		while (seq_ph != PH_IDLE) begin
			offer('{1'b1, REQ_NONE, 8'h00, 1'b0, 1'b0, 1'b1}, 1'b0, '0);
		end
	endtask

	task automatic set_clear_limit(input logic [7:0] value);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		pulse_limit = value;
		cfg_wr_en <= 1'b0;
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : out_side
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 28);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lines.size() == 0) begin
				log_mismatch("result with no item waiting for it");
			end else begin
				want = expected_lines.pop_front();
				n_checked++;
				if (scl_out !== want.scl_out)
					log_mismatch($sformatf("scl_out %b, want %b", scl_out, want.scl_out));
				if (sda_out !== want.sda_out)
					log_mismatch($sformatf("sda_out %b, want %b", sda_out, want.sda_out));
				if (busy_res !== want.busy_res)
					log_mismatch($sformatf("busy_res %b, want %b", busy_res, want.busy_res));
				if (byte_done !== want.byte_done)
					log_mismatch($sformatf("byte_done %b, want %b", byte_done, want.byte_done));
				if (rx_byte !== want.rx_byte)
					log_mismatch($sformatf("rx_byte %h, want %h", rx_byte, want.rx_byte));
				if (ack_level !== want.ack_level)
					log_mismatch($sformatf("ack_level %b, want %b", ack_level, want.ack_level));
				if (bus_clear_fail !== want.bus_clear_fail)
					log_mismatch($sformatf("bus_clear_fail %b, want %b", bus_clear_fail,
						want.bus_clear_fail));
			end
		end
	end

	initial begin : stimulus
		item_t it;
		int quota [5];
		logic [7:0] limits [5];
		int mark;
		int k;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'h00;
		in_valid <= 1'b0;
		tick <= 1'b0;
		req_type <= REQ_NONE;
		tx_byte <= 8'h00;
		first_byte <= 1'b0;
		last_byte <= 1'b0;
		sda_in <= 1'b1;

		seq_ph = PH_IDLE;
		seq_bits = 4'd0;
		seq_shift = 8'h00;
		seq_pulses = 8'h00;
		seq_rd = 1'b0;
		seq_last = 1'b0;
		seq_scl = 1'b1;
		seq_sda = 1'b1;
		seq_ack = 1'b1;
		seq_rx = 8'h00;
		seq_fail = 1'b0;
		pulse_limit = CLEAR_LIMIT_RESET;
		calm = 1'b0;
		want_hold = 1'b0;
		txn_open = 1'b0;
		sda_stuck = 1'b0;
		big_stuck_due = 1'b0;
		stuck_pct = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (byte_plan[i]) begin
			it.tick = logic'($urandom_range(0, 1));
			it.req_type = byte_plan[i].req;
			it.tx_byte = byte_plan[i].tx;
			it.first_byte = byte_plan[i].first;
			it.last_byte = byte_plan[i].last;
			it.sda_in = pick_sda(byte_plan[i].sda);
			offer(it, byte_plan[i].typed, byte_plan[i].want);
			// same request kept on the port while busy: must be ignored
			while (seq_ph != PH_IDLE) begin
				it.tick = ($urandom_range(0, 99) < 75);
				it.sda_in = pick_sda(byte_plan[i].sda);
				offer(it, 1'b0, '0);
			end
		end

		quota = '{130, 130, 520, 130, 130};
		limits = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd2};
		for (int p = 0; p < 5; p++) begin
			set_clear_limit(limits[p]);
			stuck_pct = (limits[p] > 8'd16) ? 0 : 10;
			big_stuck_due = (limits[p] == 8'd255);
			calm = (p == 1) || (p == 3);
			if (p == 1) want_hold = 1'b1;
			mark = n_active;
			k = 0;
			while (n_active - mark < quota[p]) begin
				if (p == 1 && k == 150) calm = 1'b0;
				offer(next_random_item(), 1'b0, '0);
				k++;
			end
			run_to_idle();
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d items (%0d stepping), %0d results checked", n_items, n_active,
			n_checked);
		$display("%0d writes and %0d reads completed, %0d starts failed bus clear, limits 0..255",
			n_writes_done, n_reads_done, n_clear_fails);
		if (expected_lines.size() != 0) begin
			log_mismatch($sformatf("%0d results never arrived", expected_lines.size()));
		end
		if (n_mismatch == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

@@ i2c_master_byte_engine_top.f @@
sv/i2cmbe_pkg.sv
sv/i2cmbe_core.sv
sv/i2c_master_byte_engine_top.sv
verif/testbench.sv
